/* rtl/rbbpd_pkg.sv */
// Shared types, widths and register indexes of the ramped bang-bang position drive.
package rbbpd_pkg;

   localparam int POS_W  = 16;
   localparam int RAMP_W = 16;
   localparam int ON_W   = 10;
   localparam int DIR_W  = 2;
   localparam int IDX_W  = 3;

   localparam int CYCLE_MS_DEFAULT  = 20;
   localparam int DEAD_BAND_DEFAULT = 50;

   localparam logic [IDX_W-1:0] REG_MIN_POSITION      = 3'd0;
   localparam logic [IDX_W-1:0] REG_MAX_POSITION      = 3'd1;
   localparam logic [IDX_W-1:0] REG_PULL_RAMP_MS      = 3'd2;
   localparam logic [IDX_W-1:0] REG_LOOSEN_RAMP_MS    = 3'd3;
   localparam logic [IDX_W-1:0] REG_PULL_INITIAL_ON   = 3'd4;
   localparam logic [IDX_W-1:0] REG_PULL_ON_STEP      = 3'd5;
   localparam logic [IDX_W-1:0] REG_LOOSEN_INITIAL_ON = 3'd6;
   localparam logic [IDX_W-1:0] REG_LOOSEN_ON_STEP    = 3'd7;

   typedef enum logic [DIR_W-1:0] {
      DIR_IDLE   = 2'd0,
      DIR_PULL   = 2'd1,
      DIR_LOOSEN = 2'd2
   } dir_type;

   typedef struct packed {
      logic [POS_W-1:0]  min_position;
      logic [POS_W-1:0]  max_position;
      logic [RAMP_W-1:0] pull_ramp_ms;
      logic [RAMP_W-1:0] loosen_ramp_ms;
      logic [ON_W-1:0]   pull_initial_on;
      logic [ON_W-1:0]   pull_on_step;
      logic [ON_W-1:0]   loosen_initial_on;
      logic [ON_W-1:0]   loosen_on_step;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] measured_position;
      logic             allow_drive;
      logic             setpoint_valid;
      logic [POS_W-1:0] setpoint;
   } item_type;

   typedef struct packed {
      logic             motor_enable;
      logic [DIR_W-1:0] motor_direction;
      logic             solenoid_closed;
   } result_type;

endpackage

/* rtl/rbbpd_csr.sv */
// Configuration register file of the ramped bang-bang position drive.
module rbbpd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [rbbpd_pkg::IDX_W-1:0]   csr_index,
   input  logic [rbbpd_pkg::POS_W-1:0]   csr_data,
   output rbbpd_pkg::cfg_type            cfg
);

   localparam rbbpd_pkg::cfg_type CFG_RESET = '{
      max_position: {rbbpd_pkg::POS_W{1'b1}},
      default:      '0
   };

   rbbpd_pkg::cfg_type cfg_ff;
   rbbpd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rbbpd_pkg::REG_MIN_POSITION:      cfg_in.min_position   = csr_data;
            rbbpd_pkg::REG_MAX_POSITION:      cfg_in.max_position   = csr_data;
            rbbpd_pkg::REG_PULL_RAMP_MS:      cfg_in.pull_ramp_ms   = csr_data;
            rbbpd_pkg::REG_LOOSEN_RAMP_MS:    cfg_in.loosen_ramp_ms = csr_data;
            rbbpd_pkg::REG_PULL_INITIAL_ON:
               cfg_in.pull_initial_on = csr_data[rbbpd_pkg::ON_W-1:0];
            rbbpd_pkg::REG_PULL_ON_STEP:
               cfg_in.pull_on_step = csr_data[rbbpd_pkg::ON_W-1:0];
            rbbpd_pkg::REG_LOOSEN_INITIAL_ON:
               cfg_in.loosen_initial_on = csr_data[rbbpd_pkg::ON_W-1:0];
            rbbpd_pkg::REG_LOOSEN_ON_STEP:
               cfg_in.loosen_on_step = csr_data[rbbpd_pkg::ON_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/rbbpd_core.sv */
// Drive state and single-pass tick update of the ramped bang-bang position drive.
module rbbpd_core #(
   parameter int CYCLE_MS  = rbbpd_pkg::CYCLE_MS_DEFAULT,
   parameter int DEAD_BAND = rbbpd_pkg::DEAD_BAND_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  rbbpd_pkg::item_type    item,
   input  rbbpd_pkg::cfg_type     cfg,
   output rbbpd_pkg::result_type  result
);

   localparam int POS_W   = rbbpd_pkg::POS_W;
   localparam int RAMP_W  = rbbpd_pkg::RAMP_W;
   localparam int ON_W    = rbbpd_pkg::ON_W;
   localparam int PHASE_W = (CYCLE_MS > 1) ? $clog2(CYCLE_MS) : 1;
   localparam int CYC_W   = $clog2((2 ** RAMP_W - 1) / CYCLE_MS + 1);
   localparam int PROD_W  = CYC_W + ON_W;
   localparam int OT_W    = PROD_W + 1;
   localparam logic [PHASE_W-1:0] PH_LAST = PHASE_W'(CYCLE_MS - 1);
   localparam logic [POS_W-1:0]   DB      = POS_W'(DEAD_BAND);

   function automatic logic in_band(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
      logic [POS_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d < DB;
   endfunction

   logic [POS_W-1:0]   target_ff, target_in;
   rbbpd_pkg::dir_type move_ff, move_in;
   logic [RAMP_W-1:0]  elapsed_ff, elapsed_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CYC_W-1:0]   cycles_ff, cycles_in;
   logic               latch_ff, latch_in;
   rbbpd_pkg::dir_type bridge_ff, bridge_in;

   logic [POS_W-1:0]   clamp_lo, clamped;
   logic               sp_band, same_way, restart;
   logic [RAMP_W-1:0]  elapsed_eff, ramp_sel;
   logic [PHASE_W-1:0] phase_eff;
   logic [CYC_W-1:0]   cycles_eff;
   logic [ON_W-1:0]    step_sel, init_sel;
   logic [PROD_W-1:0]  product;
   logic [OT_W-1:0]    on_time;
   logic               elapsed_sat;

   assign clamp_lo = (item.setpoint < cfg.min_position) ? cfg.min_position : item.setpoint;
   assign clamped  = (clamp_lo > cfg.max_position) ? cfg.max_position : clamp_lo;
   assign sp_band  = in_band(item.measured_position, clamped);
   assign same_way = ((clamped > item.measured_position) && (move_ff == rbbpd_pkg::DIR_PULL))
                  || ((clamped < item.measured_position) && (move_ff == rbbpd_pkg::DIR_LOOSEN));
   assign restart  = item.setpoint_valid && !sp_band && !same_way;

   assign step_sel = (move_ff == rbbpd_pkg::DIR_PULL) ? cfg.pull_on_step : cfg.loosen_on_step;
   assign product  = PROD_W'(cycles_ff) * PROD_W'(step_sel);

   always_comb begin
      target_in = item.setpoint_valid ? clamped : target_ff;
      move_in   = move_ff;
      if (restart) begin
         move_in = (clamped > item.measured_position) ? rbbpd_pkg::DIR_PULL
                                                      : rbbpd_pkg::DIR_LOOSEN;
      end
      elapsed_eff = restart ? '0 : elapsed_ff;
      phase_eff   = restart ? '0 : phase_ff;
      cycles_eff  = restart ? '0 : cycles_ff;

      if (move_in == rbbpd_pkg::DIR_PULL) begin
         ramp_sel = cfg.pull_ramp_ms;
         init_sel = cfg.pull_initial_on;
      end else begin
         ramp_sel = cfg.loosen_ramp_ms;
         init_sel = cfg.loosen_initial_on;
      end
      on_time = OT_W'(init_sel) + (restart ? '0 : OT_W'(product));

      latch_in  = latch_ff;
      bridge_in = bridge_ff;
      if (item.setpoint_valid && sp_band) begin
         latch_in = 1'b0;
      end
      if (!item.allow_drive) begin
         latch_in = 1'b0;
      end
      if (move_in != rbbpd_pkg::DIR_IDLE) begin
         if (!item.allow_drive || in_band(item.measured_position, target_in)) begin
            latch_in = 1'b0;
         end else begin
            bridge_in = (item.measured_position < target_in) ? rbbpd_pkg::DIR_PULL
                                                             : rbbpd_pkg::DIR_LOOSEN;
            latch_in = 1'b1;
            if ((elapsed_eff <= ramp_sel) && (OT_W'(phase_eff) > on_time)) begin
               latch_in = 1'b0;
            end
         end
      end

      elapsed_sat = &elapsed_eff;
      elapsed_in  = elapsed_eff;
      phase_in    = phase_eff;
      cycles_in   = cycles_eff;
      if (!elapsed_sat) begin
         elapsed_in = elapsed_eff + RAMP_W'(1);
         if (phase_eff == PH_LAST) begin
            phase_in  = '0;
            cycles_in = cycles_eff + CYC_W'(1);
         end else begin
            phase_in = phase_eff + PHASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         move_ff    <= rbbpd_pkg::DIR_IDLE;
         elapsed_ff <= '0;
         phase_ff   <= '0;
         cycles_ff  <= '0;
         latch_ff   <= 1'b0;
         bridge_ff  <= rbbpd_pkg::DIR_IDLE;
      end else if (step) begin
         target_ff  <= target_in;
         move_ff    <= move_in;
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
         cycles_ff  <= cycles_in;
         latch_ff   <= latch_in;
         bridge_ff  <= bridge_in;
      end
   end

   assign result.motor_enable    = latch_in;
   assign result.motor_direction = bridge_in;
   assign result.solenoid_closed = item.allow_drive;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_LAST)
      else $error("Cycle phase counter left its range.");

   a_restart_timer: assert property (@(posedge clock) disable iff (reset)
      step && restart |=> elapsed_ff == RAMP_W'(1))
      else $error("Ramp timer did not restart.");

   a_enable_has_dir: assert property (@(posedge clock) disable iff (reset)
      latch_ff |-> bridge_ff != rbbpd_pkg::DIR_IDLE && move_ff != rbbpd_pkg::DIR_IDLE)
      else $error("Motor enabled without a drive direction.");

   a_disallow_stops: assert property (@(posedge clock) disable iff (reset)
      step && !item.allow_drive |=> !latch_ff)
      else $error("Motor left enabled on a disallowed tick.");

endmodule

/* rtl/ramped_bang_bang_position_drive.sv */
// Top level of the ramped bang-bang position drive: stream ports, input and result registers.
// One word on req is one millisecond tick and gives exactly one word on rsp. A tick is taken
// every clock cycle unless a stall on rsp holds the pipe; it is held in the input register
// and is updated against the drive state in a single pass into the result register, from
// which its result is offered on rsp. Configuration writes are taken in every cycle and
// belong between ticks only.
module ramped_bang_bang_position_drive #(
   parameter int CYCLE_MS  = rbbpd_pkg::CYCLE_MS_DEFAULT,
   parameter int DEAD_BAND = rbbpd_pkg::DEAD_BAND_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // measured_position [15:0], allow_drive [16], setpoint [32:17], zero [39:33]
   input  logic [39:0]                  req_tdata,
   // setpoint_valid [0]
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // motor_enable [0], motor_direction [2:1], solenoid_closed [3], zero [7:4]
   output logic [7:0]                   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rbbpd_pkg::IDX_W-1:0]  csr_index,
   input  logic [rbbpd_pkg::POS_W-1:0]  csr_data
);

   rbbpd_pkg::cfg_type    cfg;
   rbbpd_pkg::item_type   item_ff, item_in;
   rbbpd_pkg::result_type result, rsp_ff;
   logic                  in_valid_ff, in_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance, step, req_fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign item_in.measured_position = req_tdata[15:0];
   assign item_in.allow_drive       = req_tdata[16];
   assign item_in.setpoint          = req_tdata[32:17];
   assign item_in.setpoint_valid    = req_tuser;

   assign in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   rbbpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rbbpd_core #(
      .CYCLE_MS  (CYCLE_MS),
      .DEAD_BAND (DEAD_BAND)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.solenoid_closed, rsp_ff.motor_direction,
                        rsp_ff.motor_enable};

endmodule
